[sv/sorted_deadline_timer_queue_core_defines.svh]
`ifndef SORTED_DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH

// Property that must hold in the same cycle as its condition, ignored in reset.
`define SDTQ_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Property that must hold in the cycle after its condition, ignored in reset.
`define SDTQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[sv/sdtq_pkg.sv]
package sdtq_pkg;

    // Command codes carried in the command field.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_EXPIRED  = 2'd2;

    // Operations of the shared adder.
    localparam logic ALU_OP_ADD_SAT = 1'b0;
    localparam logic ALU_OP_LE      = 1'b1;

    // One command transfer.
    typedef struct packed {
        logic        command;
        logic [30:0] duration;
        logic [15:0] handle;
    } t_cmd;

    // One result transfer.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] expired_handle;
        logic [31:0] deadline;
        logic        last;
    } t_res;

    // One stored timer.
    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] handle;
    } t_entry;

    // Request to the shared adder.
    typedef struct packed {
        logic        op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    // Answer of the shared adder: flag is the carry out, which for a compare
    // means a <= b.
    typedef struct packed {
        logic [31:0] sum;
        logic        flag;
    } t_alu_rsp;

endpackage

[sv/sdtq_alu.sv]
module sdtq_alu (
    input  sdtq_pkg::t_alu_req i_req,
    output sdtq_pkg::t_alu_rsp o_rsp
);

    logic [31:0] x;
    logic [31:0] y;
    logic        cin;
    logic [32:0] s;

    // Saturating add uses a + b; the compare works out b - a and keeps the carry.
    always_comb begin
        unique case (i_req.op)
            sdtq_pkg::ALU_OP_ADD_SAT: begin
                x   = i_req.a;
                y   = i_req.b;
                cin = 1'b0;
            end
            sdtq_pkg::ALU_OP_LE: begin
                x   = i_req.b;
                y   = ~i_req.a;
                cin = 1'b1;
            end
            default: begin
                x   = i_req.a;
                y   = i_req.b;
                cin = 1'b0;
            end
        endcase
    end

    assign s = {1'b0, x} + {1'b0, y} + {32'd0, cin};

    // An add that carries out saturates at the largest value.
    assign o_rsp.sum  = ((i_req.op == sdtq_pkg::ALU_OP_ADD_SAT) && s[32]) ? '1 : s[31:0];
    assign o_rsp.flag = s[32];

endmodule

[sv/sorted_deadline_timer_queue_core.sv]
// Sorted deadline timer queue.
// Command channel (i_cmd_valid, o_cmd_stall, i_cmd): a tick counts one second
// of uptime, an add queues a handle with deadline uptime plus duration.
// Result channel (o_res_valid, i_res_stall, o_res): one status result per add,
// one expired result per due timer on a tick, with last set on the final one.
// A tick that finds nothing due gives no result.
// Timers are held in a circular memory ordered by deadline; one shared adder
// does the deadline sum, the uptime increment and every compare.
// An add walks back from the tail one entry a cycle, moving each queued timer
// whose deadline is later than the new one up one place, and stops at the
// first timer due no later than the new one; a full queue rejects the add
// without a walk. A tick reads the head only when the queue is not empty and
// gives one expired result per due timer. The command channel stalls from the
// cycle after a transfer until the command is finished. The output register
// lets a command be taken while the previous result still waits; while the
// receiver stalls, the expiry walk holds.
// Reset clears the uptime and the queue; the block takes commands at once.
module sorted_deadline_timer_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_stall,
    input  sdtq_pkg::t_cmd   i_cmd,
    output logic             o_res_valid,
    input  logic             i_res_stall,
    output sdtq_pkg::t_res   o_res
);

`include "sorted_deadline_timer_queue_core_defines.svh"

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [IW:0]   DEPTH_W = (IW + 1)'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_CMP = 3'd1;
    localparam logic [2:0] S_INS_PUT = 3'd2;
    localparam logic [2:0] S_TCK_CMP = 3'd3;
    localparam logic [2:0] S_TCK_NXT = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [31:0]       r_uptime, n_uptime;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_idx, n_idx;
    logic [31:0]       r_key, n_key;
    logic [15:0]       r_hnd, n_hnd;
    logic [1:0]        r_kind, n_kind;
    logic              r_res_valid, n_res_valid;
    sdtq_pkg::t_res    r_res, n_res;

    sdtq_pkg::t_entry  mem [QUEUE_DEPTH];
    sdtq_pkg::t_entry  r_rd;
    logic              rd_en;
    logic [IW-1:0]     rd_off;
    logic              wr_en;
    logic [IW-1:0]     wr_off;
    sdtq_pkg::t_entry  wr_data;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     head_inc;

    sdtq_pkg::t_alu_req alu_req;
    sdtq_pkg::t_alu_rsp alu_rsp;

    logic cmd_acc;
    logic res_free;
    logic le;

    // Offset from the head of the queue to a memory address, wrapping at the depth.
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[IW-1:0];
    endfunction

    assign cmd_acc     = i_cmd_valid && (r_state == S_IDLE);
    assign res_free    = !r_res_valid || !i_res_stall;
    assign o_cmd_stall = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign rd_addr  = wrap_add(r_head, rd_off);
    assign wr_addr  = wrap_add(r_head, wr_off);
    assign head_inc = wrap_add(r_head, IW'(1));

    // Operand selection for the shared adder.
    always_comb begin
        if (r_state == S_IDLE) begin
            alu_req.op = sdtq_pkg::ALU_OP_ADD_SAT;
            alu_req.a  = r_uptime;
            alu_req.b  = (i_cmd.command == sdtq_pkg::CMD_ADD) ?
                         {1'b0, i_cmd.duration} : 32'd1;
        end else begin
            alu_req.op = sdtq_pkg::ALU_OP_LE;
            alu_req.a  = r_rd.deadline;
            alu_req.b  = (r_state == S_INS_CMP) ? r_key : r_uptime;
        end
    end

    sdtq_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign le = alu_rsp.flag;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_uptime    = r_uptime;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_key       = r_key;
        n_hnd       = r_hnd;
        n_kind      = r_kind;
        n_res_valid = r_res_valid && i_res_stall;
        n_res       = r_res;
        rd_en       = 1'b0;
        rd_off      = '0;
        wr_en       = 1'b0;
        wr_off      = r_idx;
        wr_data     = {r_key, r_hnd};

        unique case (r_state)
            S_IDLE: begin
                if (cmd_acc) begin
                    if (i_cmd.command == sdtq_pkg::CMD_ADD) begin
                        n_key = alu_rsp.sum;
                        n_hnd = i_cmd.handle;
                        if (r_count == DEPTH_C) begin
                            n_kind  = sdtq_pkg::KIND_REJECTED;
                            n_state = S_OUT;
                        end else if (r_count == '0) begin
                            n_idx   = '0;
                            n_state = S_INS_PUT;
                        end else begin
                            n_idx   = IW'(r_count);
                            rd_en   = 1'b1;
                            rd_off  = IW'(r_count - 1'b1);
                            n_state = S_INS_CMP;
                        end
                    end else begin
                        n_uptime = alu_rsp.sum;
                        if (r_count != '0) begin
                            rd_en   = 1'b1;
                            n_state = S_TCK_CMP;
                        end
                    end
                end
            end
            // Walk back from the tail, moving later entries up one place.
            S_INS_CMP: begin
                if (le) begin
                    n_state = S_INS_PUT;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = r_rd;
                    n_idx   = r_idx - 1'b1;
                    if (r_idx == IW'(1)) begin
                        n_state = S_INS_PUT;
                    end else begin
                        rd_en  = 1'b1;
                        rd_off = r_idx - IW'(2);
                    end
                end
            end
            S_INS_PUT: begin
                wr_en   = 1'b1;
                n_count = r_count + 1'b1;
                n_kind  = sdtq_pkg::KIND_ACCEPTED;
                n_state = S_OUT;
            end
            // First head check of a tick: nothing is pending yet.
            S_TCK_CMP: begin
                if (le) begin
                    n_key   = r_rd.deadline;
                    n_hnd   = r_rd.handle;
                    n_kind  = sdtq_pkg::KIND_EXPIRED;
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                    if (r_count == CW'(1)) begin
                        n_state = S_OUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_off  = IW'(1);
                        n_state = S_TCK_NXT;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            // The pending expiry goes out once the next head tells whether it is last.
            S_TCK_NXT: begin
                if (res_free) begin
                    n_res_valid          = 1'b1;
                    n_res.kind           = r_kind;
                    n_res.expired_handle = r_hnd;
                    n_res.deadline       = r_key;
                    n_res.last           = !le;
                    if (le) begin
                        n_key   = r_rd.deadline;
                        n_hnd   = r_rd.handle;
                        n_head  = head_inc;
                        n_count = r_count - 1'b1;
                        if (r_count == CW'(1)) begin
                            n_state = S_OUT;
                        end else begin
                            rd_en  = 1'b1;
                            rd_off = IW'(1);
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (res_free) begin
                    n_res_valid          = 1'b1;
                    n_res.kind           = r_kind;
                    n_res.expired_handle = r_hnd;
                    n_res.deadline       = r_key;
                    n_res.last           = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_uptime    <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_uptime    <= n_uptime;
            r_count     <= n_count;
            r_head      <= n_head;
            r_res_valid <= n_res_valid;
        end
    end

    // Working and result payload.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_key  <= n_key;
        r_hnd  <= n_hnd;
        r_kind <= n_kind;
        r_res  <= n_res;
    end

    // Timer memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    `SDTQ_ASSERT_SAME(a_count_bound, 1'b1, r_count <= DEPTH_C,
        "queue holds more timers than its depth")
    `SDTQ_ASSERT_NEXT(a_full_rejects,
        cmd_acc && (i_cmd.command == sdtq_pkg::CMD_ADD) && (r_count == DEPTH_C),
        (r_state == S_OUT) && (r_kind == sdtq_pkg::KIND_REJECTED),
        "add to a full queue was not rejected")
    `SDTQ_ASSERT_NEXT(a_insert_counts, r_state == S_INS_PUT,
        r_count == CW'($past(r_count) + 1'b1),
        "insertion did not add one timer to the count")
    `SDTQ_ASSERT_SAME(a_tick_has_entries,
        (r_state == S_TCK_CMP) || (r_state == S_TCK_NXT),
        r_count != '0,
        "expiry walk running on an empty queue")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 420;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 40;

    // A command waiting to be sent; wait_drain holds it back until every
    // predicted result has been transferred.
    typedef struct {
        sdtq_pkg::t_cmd cmd;
        bit             wait_drain;
    } t_pending_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cmd_valid = 1'b0;
    logic o_cmd_stall;
    sdtq_pkg::t_cmd i_cmd = '0;
    logic o_res_valid;
    logic i_res_stall = 1'b0;
    sdtq_pkg::t_res o_res;

    t_pending_cmd   pending_cmds[$];
    sdtq_pkg::t_res expected_results[$];

    // Timer list of the predictor, kept in deadline order.
    sdtq_pkg::t_entry timer_list[$];
    logic [31:0]      uptime_now = '0;

    int n_cmds_total = 0;
    int n_cmds_taken = 0;
    int n_predicted = 0;
    int n_results_seen = 0;
    int n_errors = 0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_phase = 0;
    int idle_cycles = 0;

    sorted_deadline_timer_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_stall (o_cmd_stall),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_error(input string msg);
        if (n_errors < 10) begin
            $display("%0t: %s", $realtime, msg);
        end
        n_errors++;
    endtask

    task automatic queue_cmd(input logic command, input logic [30:0] dur,
                             input logic [15:0] hnd, input bit hold);
        t_pending_cmd p;
        p.cmd.command  = command;
        p.cmd.duration = dur;
        p.cmd.handle   = hnd;
        p.wait_drain   = hold;
        pending_cmds.push_back(p);
        n_cmds_total++;
    endtask

    // Apply one accepted command to the timer list and record the results
    // it must produce.
    task automatic advance_timer_model(input sdtq_pkg::t_cmd c);
        sdtq_pkg::t_res   r;
        sdtq_pkg::t_entry e;
        logic [32:0]      total;
        logic [31:0]      dl;
        int               pos;
        int               n_due;
        if (c.command == sdtq_pkg::CMD_ADD) begin
            total = {1'b0, uptime_now} + {2'b00, c.duration};
            dl = total[32] ? 32'hFFFF_FFFF : total[31:0];
            r.expired_handle = c.handle;
            r.deadline       = dl;
            r.last           = 1'b1;
            if (timer_list.size() >= QUEUE_DEPTH) begin
                r.kind = sdtq_pkg::KIND_REJECTED;
            end else begin
                // New timers go behind every timer due at the same time.
                pos = timer_list.size();
                while (pos > 0 && timer_list[pos - 1].deadline > dl) begin
                    pos--;
                end
                e.deadline = dl;
                e.handle   = c.handle;
                timer_list.insert(pos, e);
                r.kind = sdtq_pkg::KIND_ACCEPTED;
            end
            expected_results.push_back(r);
            n_predicted++;
        end else begin
            if (uptime_now != 32'hFFFF_FFFF) begin
                uptime_now++;
            end
            n_due = 0;
            while (n_due < timer_list.size() && timer_list[n_due].deadline <= uptime_now) begin
                n_due++;
            end
            for (int i = 0; i < n_due; i++) begin
                e = timer_list.pop_front();
                r.kind           = sdtq_pkg::KIND_EXPIRED;
                r.expired_handle = e.handle;
                r.deadline       = e.deadline;
                r.last           = (i == n_due - 1);
                expected_results.push_back(r);
                n_predicted++;
            end
        end
    endtask

    // Command driver: sends queued commands in bursts with gaps between them.
    always @(posedge i_clk) begin : cmd_driver
        t_pending_cmd p;
        logic         taken;
        logic         present;
        taken = i_cmd_valid && !o_cmd_stall;
        if (taken) begin
            advance_timer_model(i_cmd);
            n_cmds_taken <= n_cmds_taken + 1;
        end
        if (i_rst_n && (taken || !i_cmd_valid)) begin
            present = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].wait_drain && n_results_seen != n_predicted)) begin
                p = pending_cmds.pop_front();
                i_cmd <= p.cmd;
                present = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            i_cmd_valid <= present;
        end
    end

    // Result stall pattern: modes of random length with none, light or heavy
    // back-pressure.
    always @(posedge i_clk) begin : res_stall_gen
        if (stall_phase == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            stall_phase <= $urandom_range(20, 80);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: begin
                i_res_stall <= 1'b0;
            end
            1: begin
                i_res_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
                i_res_stall <= ($urandom_range(0, 3) != 0);
            end
        endcase
    end

    // Result monitor: every result transfer is checked against the oldest
    // prediction.
    always @(posedge i_clk) begin : res_monitor
        sdtq_pkg::t_res want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            n_results_seen <= n_results_seen + 1;
            if (expected_results.size() == 0) begin
                report_error($sformatf("unexpected result kind=%0d handle=%h deadline=%h last=%b",
                                       o_res.kind, o_res.expired_handle, o_res.deadline,
                                       o_res.last));
            end else begin
                want = expected_results.pop_front();
                if (o_res.kind !== want.kind ||
                    o_res.expired_handle !== want.expired_handle ||
                    o_res.deadline !== want.deadline ||
                    o_res.last !== want.last) begin
                    report_error($sformatf({"result mismatch: expected kind=%0d handle=%h ",
                                            "deadline=%h last=%b, got kind=%0d handle=%h ",
                                            "deadline=%h last=%b"},
                                           want.kind, want.expired_handle, want.deadline,
                                           want.last, o_res.kind, o_res.expired_handle,
                                           o_res.deadline, o_res.last));
                end
            end
        end
    end

    // Watchdog: the run is abandoned when no transfer happens for too long.
    always @(posedge i_clk) begin : watchdog
        if ((i_cmd_valid && !o_cmd_stall) || (o_res_valid && !i_res_stall)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        bit         fill_phase;
        logic       command;
        logic [30:0] dur;
        int         pick;

        // Directed part. A tick on an empty queue gives nothing.
        queue_cmd(sdtq_pkg::CMD_TICK, 31'd0, 16'h0000, 1'b0);
        // A zero duration timer waits for the next tick.
        queue_cmd(sdtq_pkg::CMD_ADD, 31'd0, 16'hFFFF, 1'b0);
        queue_cmd(sdtq_pkg::CMD_TICK, 31'h7FFF_FFFF, 16'hFFFF, 1'b0);
        // Two timers with the largest duration and the same deadline.
        queue_cmd(sdtq_pkg::CMD_ADD, 31'h7FFF_FFFF, 16'h0001, 1'b0);
        queue_cmd(sdtq_pkg::CMD_ADD, 31'h7FFF_FFFF, 16'h0002, 1'b0);
        // Equal deadlines must leave in arrival order; an earlier one jumps ahead.
        queue_cmd(sdtq_pkg::CMD_ADD, 31'd2, 16'hAAAA, 1'b0);
        queue_cmd(sdtq_pkg::CMD_ADD, 31'd2, 16'h5555, 1'b0);
        queue_cmd(sdtq_pkg::CMD_ADD, 31'd1, 16'h1234, 1'b0);
        queue_cmd(sdtq_pkg::CMD_TICK, 31'd0, 16'h0000, 1'b0);
        queue_cmd(sdtq_pkg::CMD_TICK, 31'd0, 16'h0000, 1'b0);
        // Fill the queue, then one add that must be rejected.
        for (int k = 0; k < QUEUE_DEPTH - 2; k++) begin
            queue_cmd(sdtq_pkg::CMD_ADD, 31'(k % 4), 16'(16'h0100 + k), 1'b0);
        end
        queue_cmd(sdtq_pkg::CMD_ADD, 31'd9, 16'hBEEF, 1'b0);

        // Random part: alternating phases that favour adds or ticks, so the
        // queue keeps filling up and draining.
        fill_phase = 1'b0;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 30 == 0) begin
                fill_phase = !fill_phase;
            end
            if (fill_phase) begin
                command = ($urandom_range(0, 3) != 0) ? sdtq_pkg::CMD_ADD : sdtq_pkg::CMD_TICK;
            end else begin
                command = ($urandom_range(0, 3) == 0) ? sdtq_pkg::CMD_ADD : sdtq_pkg::CMD_TICK;
            end
            pick = $urandom_range(0, 99);
            if (command == sdtq_pkg::CMD_ADD && pick < 2) begin
                dur = 31'($urandom());
            end else if (pick < 10) begin
                dur = 31'd0;
            end else begin
                dur = 31'($urandom_range(1, 12));
            end
            if (command == sdtq_pkg::CMD_TICK && $urandom_range(0, 1) == 0) begin
                dur = 31'($urandom());
            end
            queue_cmd(command, dur, 16'($urandom()), (k == 0 || k == RANDOM_ITEMS / 2));
        end

        // Reset, once, at the start of the run.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every command is taken and every result has arrived.
        do begin
            @(posedge i_clk);
        end while (n_cmds_taken != n_cmds_total || n_results_seen != n_predicted);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
        end
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
